// ===== hdl/smd_pkg.sv =====
// Shared types, opcodes and lookup functions for the seven-segment display driver.
`default_nettype none

package smd_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int IN_DATA_W   = 40;
  localparam int IN_USER_W   = 3;
  localparam int OUT_DATA_W  = 16;
  localparam int NUM_W       = 16;

  typedef enum logic [2:0] {
    OP_SET_DIGIT   = 3'd0,
    OP_TIME        = 3'd1,
    OP_NUMBER      = 3'd2,
    OP_SET_POINT   = 3'd3,
    OP_CLEAR_POINT = 3'd4,
    OP_BLANK_DIGIT = 3'd5,
    OP_BLANK_ALL   = 3'd6,
    OP_REFRESH     = 3'd7
  } op_t;

  typedef struct packed {
    logic exec;      // an input item is transferred this cycle
    logic div_step;  // run one step of the decimal split
  } smd_cmd_t;

  typedef struct packed {
    logic out_space; // the output register can take a result this cycle
    logic div_last;  // the current decimal split step is the final one
  } smd_stat_t;

  localparam logic [7:0] BLANK_BYTE = 8'hFF;

  // Active-low segment byte for a decimal digit; anything above nine is blank.
  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'd0:    g = 8'hC0;
      4'd1:    g = 8'hF9;
      4'd2:    g = 8'hA4;
      4'd3:    g = 8'hB0;
      4'd4:    g = 8'h99;
      4'd5:    g = 8'h92;
      4'd6:    g = 8'h82;
      4'd7:    g = 8'hF8;
      4'd8:    g = 8'h80;
      4'd9:    g = 8'h90;
      default: g = BLANK_BYTE;
    endcase
    return g;
  endfunction

  // k times the place weight of a split step: 10000, 1000, 100, 10.
  function automatic logic [16:0] step_multiple(input logic [1:0] step, input int k);
    logic [16:0] m;
    unique case (step)
      2'd0: m = 17'(10000 * k);
      2'd1: m = 17'(1000 * k);
      2'd2: m = 17'(100 * k);
      2'd3: m = 17'(10 * k);
    endcase
    return m;
  endfunction

  // Tens digit of a value below 64.
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    t = 3'd0;
    for (int k = 1; k <= 6; k++) begin
      if (v >= 6'(10 * k)) begin
        t = 3'(k);
      end
    end
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [5:0] base;
    base = {3'b000, tens_of(v)} * 6'd10;
    return 4'(v - base);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/smd_ctrl.sv =====
// Controller: input handshake and the sequencing of the multi-cycle number command.
`default_nettype none

module smd_ctrl import smd_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  input  wire logic [2:0]     op,
  output logic                in_tready,
  input  wire smd_stat_t      stat,
  output smd_cmd_t            cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // A refresh tick needs room in the output register; commands do not.
  assign in_tready = (state_r == ST_IDLE) &&
                     ((op_t'(op) != OP_REFRESH) || stat.out_space);
  assign accept    = in_tvalid && in_tready;

  assign cmd.exec     = accept;
  assign cmd.div_step = (state_r == ST_DIV);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (op_t'(op) == OP_NUMBER)) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat.div_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/smd_datapath.sv =====
// Datapath: digit store, scan index, decimal split unit and output register.
`default_nettype none

module smd_datapath import smd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire smd_cmd_t              cmd,
  output smd_stat_t                  stat,
  input  wire logic [2:0]            op,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output logic [OUT_DATA_W-1:0]      out_data
);

  logic [3:0]       digit_value;
  logic [2:0]       position;
  logic [4:0]       hours;
  logic [5:0]       minutes;
  logic [NUM_W-1:0] number;

  assign digit_value = in_data[3:0];
  assign position    = in_data[6:4];
  assign hours       = in_data[11:7];
  assign minutes     = in_data[17:12];
  assign number      = in_data[33:18];

  // Each byte is kept as seven segment bits and a point bit, so the point
  // commands need no read of the store.
  logic [6:0]       seg_r [DIGIT_COUNT];
  logic [6:0]       seg_nxt [DIGIT_COUNT];
  logic             pt_r [DIGIT_COUNT];
  logic             pt_nxt [DIGIT_COUNT];
  logic [1:0]       scan_r, scan_nxt;
  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [3:0]       dig_r [2];
  logic [3:0]       dig_nxt [2];
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_seg_r, out_seg_nxt;
  logic [3:0]       out_sel_r, out_sel_nxt;

  logic [3:0]  q;
  logic [16:0] sub;
  logic        pos_ok;
  logic [1:0]  idx;
  logic [7:0]  g [DIGIT_COUNT];

  assign pos_ok = (position[2] == 1'b0);
  assign idx    = position[1:0];

  assign stat.out_space = !out_valid_r || out_tready;
  assign stat.div_last  = (step_r == 2'd3);

  assign out_tvalid = out_valid_r;
  assign out_data   = {4'b0000, out_sel_r, out_seg_r};

  // One quotient digit per step: compare against the nine multiples of the
  // place weight and take the largest one that fits.
  always_comb begin
    q   = 4'd0;
    sub = 17'd0;
    for (int k = 1; k <= 9; k++) begin
      if ({1'b0, rem_r} >= step_multiple(step_r, k)) begin
        q   = 4'(k);
        sub = step_multiple(step_r, k);
      end
    end
  end

  always_comb begin
    seg_nxt       = seg_r;
    pt_nxt        = pt_r;
    scan_nxt      = scan_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_seg_nxt   = out_seg_r;
    out_sel_nxt   = out_sel_r;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      g[i] = BLANK_BYTE;
    end

    if (cmd.div_step) begin
      rem_nxt  = rem_r - sub[NUM_W-1:0];
      step_nxt = step_r + 2'd1;
      unique case (step_r)
        2'd1:    dig_nxt[0] = q;
        2'd2:    dig_nxt[1] = q;
        default: ;
      endcase
      if (step_r == 2'd3) begin
        g[0] = glyph(dig_r[0]);
        g[1] = glyph(dig_r[1]);
        g[2] = glyph(q);
        g[3] = glyph(rem_nxt[3:0]);
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          seg_nxt[i] = g[i][6:0];
          pt_nxt[i]  = g[i][7];
        end
      end
    end

    if (cmd.exec) begin
      unique case (op_t'(op))
        OP_SET_DIGIT: begin
          if (pos_ok && (digit_value <= 4'd9)) begin
            g[0]         = glyph(digit_value);
            seg_nxt[idx] = g[0][6:0];
            pt_nxt[idx]  = g[0][7];
          end
        end
        OP_TIME: begin
          g[0] = glyph({1'b0, tens_of({1'b0, hours})});
          g[1] = glyph(ones_of({1'b0, hours}));
          g[2] = glyph({1'b0, tens_of(minutes)});
          g[3] = glyph(ones_of(minutes));
          for (int i = 0; i < DIGIT_COUNT; i++) begin
            seg_nxt[i] = g[i][6:0];
            pt_nxt[i]  = g[i][7];
          end
        end
        OP_NUMBER: begin
          rem_nxt  = number;
          step_nxt = 2'd0;
        end
        OP_SET_POINT: begin
          if (pos_ok) begin
            pt_nxt[idx] = 1'b0;
          end
        end
        OP_CLEAR_POINT: begin
          if (pos_ok) begin
            pt_nxt[idx] = 1'b1;
          end
        end
        OP_BLANK_DIGIT: begin
          if (pos_ok) begin
            seg_nxt[idx] = BLANK_BYTE[6:0];
            pt_nxt[idx]  = BLANK_BYTE[7];
          end
        end
        OP_BLANK_ALL: begin
          for (int i = 0; i < DIGIT_COUNT; i++) begin
            seg_nxt[i] = BLANK_BYTE[6:0];
            pt_nxt[i]  = BLANK_BYTE[7];
          end
        end
        OP_REFRESH: begin
          // The scan index moves first, then the new digit is shown.
          scan_nxt      = scan_r + 2'd1;
          out_valid_nxt = 1'b1;
          out_seg_nxt   = {pt_r[scan_nxt], seg_r[scan_nxt]};
          out_sel_nxt   = ~(4'b0001 << scan_nxt);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        seg_r[i] <= 7'd0;
        pt_r[i]  <= 1'b0;
      end
      scan_r      <= 2'd0;
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      seg_r       <= seg_nxt;
      pt_r        <= pt_nxt;
      scan_r      <= scan_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    dig_r     <= dig_nxt;
    out_seg_r <= out_seg_nxt;
    out_sel_r <= out_sel_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/seven_segment_mux_display.sv =====
// Top level of the four-digit multiplexed seven-segment display driver.
//
//   Channel | Direction | Ports                          | Payload
//   --------+-----------+--------------------------------+----------------------------------
//   in_     | input     | in_tvalid/in_tready            | tuser: op; tdata: digit, time, number
//   out_    | output    | out_tvalid/out_tready          | tdata: segments, digit_select
//
// Every command except the number command completes with its transfer; the number
// command is transferred and then runs the steps of the decimal split unit, which
// produces one digit per cycle, and no input is taken meanwhile.
// A refresh tick puts one result into the output register; the tick is held
// off while that register is full and not being drained, and while a number is split.
// Reset is synchronous, active low, and clears the store to all segments lit.
`default_nettype none

module seven_segment_mux_display import smd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_USER_W-1:0]  in_tuser,   // [2:0] op
  // [3:0] digit_value, [6:4] position, [11:7] hours, [17:12] minutes,
  // [33:18] number, [39:34] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // [7:0] segments, [11:8] digit_select
);

  smd_cmd_t  cmd;
  smd_stat_t stat;

  smd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .op        (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  smd_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .op         (in_tuser),
    .in_data    (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_data   (out_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking stream testbench for the four-digit seven-segment display driver.
module testbench;
  import smd_pkg::*;

  localparam int LIMIT_CYCLES = 100000;
  localparam int TAIL_CYCLES  = 20;
  localparam int RANDOM_CMDS  = 1200;
  localparam int MAX_REPORTS  = 40;

  // Active-low glyphs for 9 down to 0, digit 0 in the lowest byte.
  localparam logic [79:0] GLYPH_ROM = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
                                       8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};
  localparam logic [7:0] DARK = 8'hFF;

  typedef struct packed {
    op_t         op;
    logic [3:0]  digit;
    logic [2:0]  pos;
    logic [4:0]  hrs;
    logic [5:0]  mins;
    logic [15:0] num;
    bit          drain;
  } disp_cmd_t;

  typedef struct packed {
    logic [7:0] seg;
    logic [3:0] sel;
  } scan_frame_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_USER_W-1:0]  in_tuser = '0;   // [2:0] op
  // [3:0] digit_value, [6:4] position, [11:7] hours, [17:12] minutes,
  // [33:18] number, [39:34] zero
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [7:0] segments, [11:8] digit_select

  disp_cmd_t   cmd_queue[$];
  scan_frame_t pending_scans[$];
  logic [7:0]  shown[4];
  logic [1:0]  scan_pos;

  int  mismatches = 0;
  int  cmds_taken = 0;
  int  ticks_taken = 0;
  int  numbers_taken = 0;
  int  scans_checked = 0;
  int  cycles = 0;
  bit  scans_idle = 1'b1;
  bit  quiet_stretch = 1'b0;

  seven_segment_mux_display uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) begin
      $display("[%0d] mismatch: %s", cycles, msg);
    end
    mismatches++;
  endtask

  function automatic logic [7:0] glyph_code(input int d);
    return GLYPH_ROM[d*8 +: 8];
  endfunction

  // Applies one transferred command to the display image; a refresh tick
  // also queues the frame the block must scan out.
  task automatic update_display(input op_t op, input logic [3:0] digit,
                                input logic [2:0] pos, input logic [4:0] hrs,
                                input logic [5:0] mins, input logic [15:0] num);
    int          n;
    scan_frame_t frame;
    case (op)
      OP_SET_DIGIT: begin
        if (pos < 4 && digit <= 9) shown[pos[1:0]] = glyph_code(digit);
      end
      OP_TIME: begin
        shown[0] = glyph_code(hrs / 10);
        shown[1] = glyph_code(hrs % 10);
        shown[2] = glyph_code(mins / 10);
        shown[3] = glyph_code(mins % 10);
      end
      OP_NUMBER: begin
        n = num % 10000;
        shown[0] = glyph_code(n / 1000);
        shown[1] = glyph_code((n / 100) % 10);
        shown[2] = glyph_code((n / 10) % 10);
        shown[3] = glyph_code(n % 10);
      end
      OP_SET_POINT: begin
        if (pos < 4) shown[pos[1:0]][7] = 1'b0;
      end
      OP_CLEAR_POINT: begin
        if (pos < 4) shown[pos[1:0]][7] = 1'b1;
      end
      OP_BLANK_DIGIT: begin
        if (pos < 4) shown[pos[1:0]] = DARK;
      end
      OP_BLANK_ALL: begin
        for (int k = 0; k < 4; k++) shown[k] = DARK;
      end
      default: begin
        scan_pos = scan_pos + 2'd1;
        frame.seg = shown[scan_pos];
        frame.sel = ~(4'b0001 << scan_pos);
        pending_scans.push_back(frame);
      end
    endcase
  endtask

  function automatic disp_cmd_t make_cmd(input op_t op, input int digit, input int pos,
                                         input int hrs, input int mins, input int num);
    disp_cmd_t c;
    c.op = op;
    c.digit = 4'(digit);
    c.pos = 3'(pos);
    c.hrs = 5'(hrs);
    c.mins = 6'(mins);
    c.num = 16'(num);
    c.drain = 1'b0;
    return c;
  endfunction

  function automatic disp_cmd_t random_cmd();
    disp_cmd_t c;
    int        r;
    c = make_cmd(OP_REFRESH, $urandom_range(15), $urandom_range(7), $urandom_range(31),
                 $urandom_range(63), $urandom_range(65535));
    r = $urandom_range(99);
    if (r < 38) c.op = OP_REFRESH;
    else if (r < 52) c.op = OP_SET_DIGIT;
    else if (r < 60) c.op = OP_TIME;
    else if (r < 70) c.op = OP_NUMBER;
    else if (r < 79) c.op = OP_SET_POINT;
    else if (r < 88) c.op = OP_CLEAR_POINT;
    else if (r < 97) c.op = OP_BLANK_DIGIT;
    else c.op = OP_BLANK_ALL;
    // Mostly commands that land on a real digit with a decimal value.
    if ($urandom_range(99) < 85) c.pos = 3'($urandom_range(3));
    if ($urandom_range(99) < 80) c.digit = 4'($urandom_range(9));
    if (c.op == OP_NUMBER && $urandom_range(3) == 0) begin
      c.num = 16'(10000 * $urandom_range(6) + $urandom_range(9999));
    end
    return c;
  endfunction

  // Input driver: presents the next queued command once the bus is free.
  always @(posedge clk) begin : drive_commands
    disp_cmd_t nxt;
    bit        hold;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      hold = cmd_queue.size() == 0;
      if (!hold) hold = cmd_queue[0].drain && (in_tvalid || !scans_idle);
      if (!hold && !quiet_stretch) hold = $urandom_range(99) < 7;
      if (hold) begin
        in_tvalid <= 1'b0;
      end else begin
        nxt = cmd_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.op;
        in_tdata  <= {6'b0, nxt.num, nxt.mins, nxt.hrs, nxt.pos, nxt.digit};
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet_stretch || ($urandom_range(99) >= 7);
    end
  end

  // Monitor: checks scan outputs, then feeds transferred commands to the predictor.
  always @(posedge clk) begin : watch_buses
    scan_frame_t want;
    op_t         op;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_scans.size() == 0) begin
          report_mismatch($sformatf("unexpected scan output %h", out_tdata));
        end else begin
          want = pending_scans.pop_front();
          if (out_tdata[7:0] !== want.seg) begin
            report_mismatch($sformatf("segments %h, wanted %h", out_tdata[7:0], want.seg));
          end
          if (out_tdata[11:8] !== want.sel) begin
            report_mismatch($sformatf("digit select %b, wanted %b",
                                      out_tdata[11:8], want.sel));
          end
          scans_checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        op = op_t'(in_tuser);
        update_display(op, in_tdata[3:0], in_tdata[6:4], in_tdata[11:7],
                       in_tdata[17:12], in_tdata[33:18]);
        cmds_taken++;
        if (op == OP_REFRESH) ticks_taken++;
        if (op == OP_NUMBER) numbers_taken++;
      end
      scans_idle    <= pending_scans.size() == 0;
      quiet_stretch <= cmds_taken >= 500 && cmds_taken < 800;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("run timed out after %0d cycles", cycles);
      $display("FAIL seven_segment_mux_display");
      $finish;
    end
  end

  initial begin
    disp_cmd_t c;
    for (int k = 0; k < 4; k++) shown[k] = 8'h00;
    scan_pos = 2'd0;

    // Store lit after reset; four ticks walk the scan all the way round.
    repeat (4) cmd_queue.push_back(make_cmd(OP_REFRESH, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_SET_DIGIT, 9, 3, 31, 63, 65535));
    cmd_queue.push_back(make_cmd(OP_SET_DIGIT, 15, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_SET_DIGIT, 5, 7, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_REFRESH, 15, 7, 31, 63, 65535));
    cmd_queue.push_back(make_cmd(OP_TIME, 0, 0, 31, 63, 0));
    cmd_queue.push_back(make_cmd(OP_REFRESH, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_REFRESH, 0, 0, 0, 0, 0));
    c = make_cmd(OP_NUMBER, 0, 0, 0, 0, 65535);
    c.drain = 1'b1;
    cmd_queue.push_back(c);
    cmd_queue.push_back(make_cmd(OP_REFRESH, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_SET_POINT, 0, 1, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_SET_POINT, 0, 4, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_CLEAR_POINT, 0, 2, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_REFRESH, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_REFRESH, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_BLANK_DIGIT, 0, 3, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_BLANK_DIGIT, 0, 6, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_REFRESH, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_BLANK_ALL, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_NUMBER, 0, 0, 0, 0, 10000));
    cmd_queue.push_back(make_cmd(OP_TIME, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_REFRESH, 0, 0, 0, 0, 0));

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      c = random_cmd();
      if (i % 200 == 150) c.drain = 1'b1;
      cmd_queue.push_back(c);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || in_tvalid) @(negedge clk);
    while (pending_scans.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_scans.size() != 0) begin
      report_mismatch($sformatf("%0d scan outputs never arrived", pending_scans.size()));
    end

    $display("%0d commands transferred: %0d refresh ticks, %0d number loads",
             cmds_taken, ticks_taken, numbers_taken);
    $display("%0d scan outputs checked, %0d mismatches", scans_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS seven_segment_mux_display");
    end else begin
      $display("FAIL seven_segment_mux_display");
    end
    $finish;
  end

endmodule

// ===== seven_segment_mux_display.f =====
hdl/smd_pkg.sv
hdl/smd_ctrl.sv
hdl/smd_datapath.sv
hdl/seven_segment_mux_display.sv
tb/sv/testbench.sv
